/* rtl/tfb_pkg.sv */
`default_nettype none

package tfb_pkg;

	// Frame limits
	localparam int MAX_WORDS = 16;
	localparam int WL_W      = $clog2(MAX_WORDS + 1);

	// Fixed header content
	localparam logic [7:0] VERSION_BYTE = 8'h01;

	// Configuration register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 1'd1;

	// Queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// One classified word, ready for the serializer
	typedef struct packed {
		logic [31:0] data_word;
		logic        first;
		logic        last;
		logic [7:0]  frame_id;
		logic [15:0] len;
		logic [7:0]  hdr;
		logic [7:0]  tgt;
	} entry_t;

	// Byte position inside the sequence emitted for one word
	typedef enum logic [3:0] {
		PH_HDR0  = 4'd0,
		PH_HDR1  = 4'd1,
		PH_HDR2  = 4'd2,
		PH_HDR3  = 4'd3,
		PH_HDR4  = 4'd4,
		PH_HDR5  = 4'd5,
		PH_DATA0 = 4'd6,
		PH_DATA1 = 4'd7,
		PH_DATA2 = 4'd8,
		PH_DATA3 = 4'd9,
		PH_SUM   = 4'd10,
		PH_ADD   = 4'd11
	} phase_t;

endpackage

`default_nettype wire

/* rtl/tfb_if.sv */
`default_nettype none

interface tfb_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [4:0]  frame_words;
	logic [7:0]  frame_id;

	modport source (output valid, output data_word, output frame_words, output frame_id,
		input ready);
	modport sink (input valid, input data_word, input frame_words, input frame_id,
		output ready);
endinterface

interface tfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;

	modport source (output valid, output out_byte, output frame_end, input ready);
	modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/telemetry_frame_builder.sv */
`default_nettype none

// Telemetry frame builder. Takes 32-bit words on word_ch and sends the frame
// one byte per beat on byte_ch: six header bytes (header marker, 0x01, target
// address, frame id, byte length low then high) ahead of a frame's first word,
// four data bytes per word low byte first, then the sum check and the add
// check after the last word; frame_end marks the add check. Word count and
// frame id are sampled on the first word only; a count of zero counts as one
// and larger counts saturate at MAX_WORDS. A middle word gives four bytes, a
// first word ten, a last word two more, all via the single byte-wide output
// register. A two-entry queue sits between the input classifier and the byte
// serializer, so the next words are accepted while earlier bytes drain.
// Configuration index 0 is the header marker (reset 0xAA), index 1 the target
// address (reset 0xFF); write them while no frame is in flight.
module telemetry_frame_builder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tfb_word_if.sink                            word_ch,
	tfb_byte_if.source                          byte_ch,
	input  wire logic                           cfg_we,
	input  wire logic [tfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [7:0]                     cfg_data
);
	import tfb_pkg::*;

	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_empty;
	entry_t q_entry;
	entry_t q_head;

	tfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_ch   (word_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	tfb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	tfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.byte_ch (byte_ch)
	);

endmodule

`default_nettype wire

/* rtl/tfb_front.sv */
`default_nettype none

module tfb_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tfb_word_if.sink                            word_ch,
	input  wire logic                           cfg_we,
	input  wire logic [tfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [7:0]                     cfg_data,
	input  wire logic                           q_full,
	output logic                                q_push,
	output tfb_pkg::entry_t                     q_entry
);
	import tfb_pkg::*;

	logic [7:0]      hdr_q;
	logic [7:0]      tgt_q;
	logic [WL_W-1:0] words_left_q;
	logic [WL_W-1:0] count_n;
	logic [WL_W-1:0] words_left_nxt;
	logic            open_frame;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= 8'hAA;
			tgt_q <= 8'hFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_BYTE:    hdr_q <= cfg_data;
				REG_TARGET_ADDRESS: tgt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the word count of a new frame to 1..MAX_WORDS
	always_comb begin
		if (word_ch.frame_words == 5'd0) begin
			count_n = WL_W'(1);
		end else if (32'(word_ch.frame_words) > 32'(MAX_WORDS)) begin
			count_n = WL_W'(MAX_WORDS);
		end else begin
			count_n = WL_W'(word_ch.frame_words);
		end
	end

	// Classify the beat: first word opens a frame, last word closes it
	assign open_frame     = (words_left_q == '0);
	assign words_left_nxt = (open_frame ? count_n : words_left_q) - WL_W'(1);

	assign word_ch.ready = !q_full;
	assign q_push        = word_ch.valid && !q_full;

	always_comb begin
		q_entry.data_word = word_ch.data_word;
		q_entry.first     = open_frame;
		q_entry.last      = (words_left_nxt == '0);
		q_entry.frame_id  = word_ch.frame_id;
		q_entry.len       = 16'({count_n, 2'b00});
		q_entry.hdr       = hdr_q;
		q_entry.tgt       = tgt_q;
	end

	// Track words still to come in the open frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_left_q <= '0;
		end else if (q_push) begin
			words_left_q <= words_left_nxt;
		end
	end

	a_words_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(words_left_q) < 32'(MAX_WORDS))
		else $error("open frame count beyond limit");

endmodule

`default_nettype wire

/* rtl/tfb_fifo.sv */
`default_nettype none

module tfb_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tfb_pkg::entry_t push_entry,
	output logic                 full,
	input  wire logic            pop,
	output tfb_pkg::entry_t      head,
	output logic                 empty
);
	import tfb_pkg::*;

	entry_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store incoming entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/tfb_back.sv */
`default_nettype none

module tfb_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tfb_pkg::entry_t head,
	input  wire logic            q_empty,
	output logic                 q_pop,
	tfb_byte_if.source           byte_ch
);
	import tfb_pkg::*;

	phase_t     phase_q;
	phase_t     eff_ph;
	phase_t     nxt_ph;
	logic       started_q;
	logic [7:0] sum_q;
	logic [7:0] add_q;
	logic [7:0] obyte_q;
	logic       oend_q;
	logic       ovalid_q;
	logic       adv;
	logic       done;
	logic       checked;
	logic [7:0] byte_nxt;
	logic [7:0] sum_base;
	logic [7:0] add_base;
	logic [7:0] sum_nxt;
	logic [7:0] add_nxt;

	// Step one byte whenever a word is queued and the output register is free or being drained
	assign adv   = !q_empty && (!ovalid_q || byte_ch.ready);
	assign q_pop = adv && done;

	// Next position in the byte sequence
	always_comb begin
		if (started_q) begin
			eff_ph = phase_q;
		end else begin
			eff_ph = head.first ? PH_HDR0 : PH_DATA0;
		end
		done   = ((eff_ph == PH_DATA3) && !head.last) || (eff_ph == PH_ADD);
		nxt_ph = phase_t'(4'(eff_ph) + 4'd1);
	end

	// Select the byte for the current position
	always_comb begin
		case (eff_ph)
			PH_HDR0:  byte_nxt = head.hdr;
			PH_HDR1:  byte_nxt = VERSION_BYTE;
			PH_HDR2:  byte_nxt = head.tgt;
			PH_HDR3:  byte_nxt = head.frame_id;
			PH_HDR4:  byte_nxt = head.len[7:0];
			PH_HDR5:  byte_nxt = head.len[15:8];
			PH_DATA0: byte_nxt = head.data_word[7:0];
			PH_DATA1: byte_nxt = head.data_word[15:8];
			PH_DATA2: byte_nxt = head.data_word[23:16];
			PH_DATA3: byte_nxt = head.data_word[31:24];
			PH_SUM:   byte_nxt = sum_q;
			PH_ADD:   byte_nxt = add_q;
			default:  byte_nxt = '0;
		endcase
	end

	// Running checks, restarted on the header marker
	always_comb begin
		checked  = (eff_ph != PH_SUM) && (eff_ph != PH_ADD);
		sum_base = (eff_ph == PH_HDR0) ? 8'd0 : sum_q;
		add_base = (eff_ph == PH_HDR0) ? 8'd0 : add_q;
		sum_nxt  = sum_base + byte_nxt;
		add_nxt  = add_base + sum_nxt;
	end

	// Sequencer and check state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			started_q <= 1'b0;
			sum_q     <= '0;
			add_q     <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (adv) begin
				ovalid_q <= 1'b1;
				if (checked) begin
					sum_q <= sum_nxt;
					add_q <= add_nxt;
				end
				if (done) begin
					started_q <= 1'b0;
				end else begin
					started_q <= 1'b1;
					phase_q   <= nxt_ph;
				end
			end else if (byte_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			obyte_q <= byte_nxt;
			oend_q  <= (eff_ph == PH_ADD);
		end
	end

	assign byte_ch.valid     = ovalid_q;
	assign byte_ch.out_byte  = obyte_q;
	assign byte_ch.frame_end = oend_q;

	a_pop_at_close: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> ((eff_ph == PH_DATA3) && !head.last) || (eff_ph == PH_ADD))
		else $error("word retired at wrong position");

	a_end_follows_add: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (eff_ph == PH_ADD)) |=> (ovalid_q && oend_q))
		else $error("closing byte not flagged");

	a_started_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> !q_empty)
		else $error("sequence in flight without a queued word");

endmodule

`default_nettype wire
